/* rtl/nntsp_pkg.sv */
// Shared types and constants for the nearest-neighbor tour block with 2-opt.
// No dependencies; the top, nntsp_ctrl and nntsp_dp import this package.
`timescale 1ns / 1ps

package nntsp_pkg;

    localparam int CITY_W = 6;
    localparam int LEN_W  = 23;
    localparam int OUT_W  = 32;
    localparam int PAD_W  = OUT_W - CITY_W - LEN_W;

    typedef enum logic [5:0] {
        S_IDLE, S_DIAG, S_JCHK, S_XY_RD, S_XY_WAIT, S_SUM, S_ROOT, S_WR1, S_WR2,
        S_NN_INIT, S_NN_POS, S_NN_RD, S_NN_CMP, S_NN_TAKE, S_NN_CLOSE, S_NN_CLOSE2,
        S_OPT_SWEEP, S_OPT_RCHK,
        S_T0, S_T1, S_T2, S_T3, S_T4,
        S_D0, S_D1, S_D2, S_D3, S_D4, S_GAIN,
        S_SW_RP, S_SW_RQ, S_SW_CAP, S_SW_WP, S_SW_WQ, S_KNEXT,
        S_EM_RD, S_EM_LD, S_EM_WAIT
    } state_t;

    typedef enum logic [3:0] {
        DS_II, DS_IJ, DS_JI, DS_PJ, DS_P0, DS_AB, DS_CD, DS_AC, DS_BD
    } dsel_t;

    typedef enum logic [1:0] {TW_ZERO, TW_BEST, TW_TP, TW_TQ} twsel_t;

    typedef enum logic [2:0] {
        CAP_NONE, CAP_A, CAP_B, CAP_C, CAP_D, CAP_P, CAP_Q, CAP_OUT
    } cap_t;

    typedef enum logic [1:0] {G_HOLD, G_LOAD, G_ADD, G_SUB} gop_t;

    typedef enum logic [2:0] {L_HOLD, L_CLR, L_ADD_BEST, L_ADD_RD, L_SUB_GAIN} lop_t;

    typedef struct packed {
        logic   xy_wr;
        logic   xy_rd;
        logic   sq_load;
        logic   root_start;
        logic   dist_wr;
        logic   dist_zero;
        logic   dist_rd;
        dsel_t  dsel;
        logic   tour_wr;
        twsel_t twsel;
        logic   tour_rd;
        cap_t   cap;
        gop_t   gop;
        lop_t   lop;
        logic   nn_init;
        logic   nn_pos;
        logic   nn_cmp;
        logic   nn_take;
    } dp_cmd_t;

    typedef struct packed {
        logic root_done;
        logic gain_pos;
    } dp_stat_t;

endpackage

/* rtl/nearest_neighbor_tour_two_opt_top.sv */
// Flow: each loaded point has its distances to all earlier points computed; one rounded
// distance uses the shared root unit, then two writes to the symmetric distance table.
// The nearest-neighbor tour is built next, then 2-opt tests with swaps are repeated
// until a clean sweep; then one result beat per city, each held until m_ready.
// Reset (aresetn low, synchronous) clears the sequencer, point count and length;
// point, distance and tour memories hold garbage until written.
`timescale 1ns / 1ps

module nearest_neighbor_tour_two_opt_top
    import nntsp_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // x_coord [COORD_BITS-1:0], y_coord [2*COORD_BITS-1:COORD_BITS], zero pad
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    input  logic                                  s_tlast,   // last_point
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // city_index [5:0], tour_length [28:6], zero pad [31:29]
    output logic [OUT_W-1:0]                      m_tdata,
    output logic                                  m_tlast    // last_city
);

    localparam int IW = $clog2(MAX_POINTS);

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [IW-1:0]    ia, ja, ta;
    logic [CITY_W-1:0] city;
    logic [LEN_W-1:0] len;

    // sequencer: owns loop counters and the stream handshakes
    nntsp_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_last  (s_tlast),
        .s_ready (s_tready),
        .m_valid (m_tvalid),
        .m_last  (m_tlast),
        .m_ready (m_tready),
        .cmd     (cmd),
        .stat    (stat),
        .ia      (ia),
        .ja      (ja),
        .ta      (ta)
    );

    // datapath: memories, root unit, gain and length arithmetic
    nntsp_dp #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .ia       (ia),
        .ja       (ja),
        .ta       (ta),
        .x_in     (s_tdata[COORD_BITS-1:0]),
        .y_in     (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .city_out (city),
        .len_out  (len)
    );

    // pack the result beat; the length repeats on every city of a set
    assign m_tdata = {PAD_W'(0), len, city};

endmodule

/* rtl/nntsp_root.sv */
// Iterative integer square root, one root bit per cycle, rounded to nearest.
// Depends on nothing beyond its parameter.
`timescale 1ns / 1ps

module nntsp_root #(
    parameter int COORD_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [2*COORD_BITS:0] operand,
    output logic                  done,
    output logic [COORD_BITS:0]   root_out
);

    localparam int OW = 2 * COORD_BITS + 2;
    localparam int QW = COORD_BITS + 1;
    localparam int RW = COORD_BITS + 3;
    localparam int NW = $clog2(COORD_BITS + 2);

    logic [OW-1:0] opnd_reg, opnd_next;
    logic [QW-1:0] root_reg, root_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;

    assign rem_sh = {rem_reg[RW-3:0], opnd_reg[OW-1:OW-2]};
    assign trial  = {root_reg, 2'b01};

    always_comb begin
        opnd_next = opnd_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            opnd_next = {1'b0, operand};
            root_next = '0;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            opnd_next = {opnd_reg[OW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[QW-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == NW'(COORD_BITS)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        opnd_reg <= opnd_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    // round up when the remainder exceeds the floor root
    assign done     = done_reg;
    assign root_out = (rem_reg > RW'(root_reg)) ? root_reg + 1'b1 : root_reg;

endmodule

/* rtl/nntsp_ctrl.sv */
// Sequencer for loading, tour building, 2-opt sweeps and emission.
// Depends on nntsp_pkg; drives nntsp_dp through dp_cmd_t and index buses.
`timescale 1ns / 1ps

module nntsp_ctrl
    import nntsp_pkg::*;
#(
    parameter int MAX_POINTS = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_last,
    output logic                          s_ready,
    output logic                          m_valid,
    output logic                          m_last,
    input  logic                          m_ready,
    output dp_cmd_t                       cmd,
    input  dp_stat_t                      stat,
    output logic [$clog2(MAX_POINTS)-1:0] ia,
    output logic [$clog2(MAX_POINTS)-1:0] ja,
    output logic [$clog2(MAX_POINTS)-1:0] ta
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int XW = CW + 2;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] r_reg, r_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] s_reg, s_next;
    logic          again_reg, again_next;
    logic          last_reg, last_next;

    logic [XW-1:0] n_x, k_x, r_x, s_x;
    logic [XW-1:0] pos_b, pos_c, pos_d, pos_p, pos_q;
    logic          room;

    function automatic logic [XW-1:0] wrap(input logic [XW-1:0] v, input logic [XW-1:0] n);
        wrap = (v >= n) ? v - n : v;
    endfunction

    assign n_x   = XW'(cnt_reg);
    assign k_x   = XW'(k_reg);
    assign r_x   = XW'(r_reg);
    assign s_x   = XW'(s_reg);
    assign pos_b = wrap(k_x + 1'b1, n_x);
    assign pos_c = wrap(k_x + r_x + 1'b1, n_x);
    assign pos_d = wrap(k_x + r_x + XW'(2), n_x);
    assign pos_p = wrap(k_x + s_x, n_x);
    assign pos_q = wrap(k_x + r_x + XW'(2) - s_x, n_x);
    assign room  = cnt_reg < CW'(MAX_POINTS);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        r_next     = r_reg;
        k_next     = k_reg;
        s_next     = s_reg;
        again_next = again_reg;
        last_next  = last_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    last_next = s_last;
                    i_next    = cnt_reg;
                    j_next    = '0;
                    if (room)        state_next = S_DIAG;
                    else if (s_last) state_next = S_NN_INIT;
                end
            end
            S_DIAG: begin
                cnt_next   = cnt_reg + 1'b1;
                state_next = S_JCHK;
            end
            S_JCHK: begin
                if (j_reg < i_reg)  state_next = S_XY_RD;
                else if (last_reg)  state_next = S_NN_INIT;
                else                state_next = S_IDLE;
            end
            S_XY_RD:   state_next = S_XY_WAIT;
            S_XY_WAIT: state_next = S_SUM;
            S_SUM:     state_next = S_ROOT;
            S_ROOT: begin
                if (stat.root_done) state_next = S_WR1;
            end
            S_WR1: state_next = S_WR2;
            S_WR2: begin
                j_next     = j_reg + 1'b1;
                state_next = S_JCHK;
            end
            S_NN_INIT: begin
                i_next     = CW'(1);
                state_next = S_NN_POS;
            end
            S_NN_POS: begin
                if (i_reg < cnt_reg) begin
                    j_next     = CW'(1);
                    state_next = S_NN_RD;
                end else begin
                    state_next = S_NN_CLOSE;
                end
            end
            S_NN_RD: state_next = S_NN_CMP;
            S_NN_CMP: begin
                j_next = j_reg + 1'b1;
                if (XW'(j_reg) + 1'b1 < n_x) state_next = S_NN_RD;
                else                         state_next = S_NN_TAKE;
            end
            S_NN_TAKE: begin
                i_next     = i_reg + 1'b1;
                state_next = S_NN_POS;
            end
            S_NN_CLOSE:  state_next = S_NN_CLOSE2;
            S_NN_CLOSE2: state_next = S_OPT_SWEEP;
            S_OPT_SWEEP: begin
                again_next = 1'b0;
                r_next     = CW'(1);
                state_next = S_OPT_RCHK;
            end
            S_OPT_RCHK: begin
                if ((r_x << 1) < n_x) begin
                    k_next     = '0;
                    state_next = S_T0;
                end else if (again_reg) begin
                    state_next = S_OPT_SWEEP;
                end else begin
                    i_next     = '0;
                    state_next = S_EM_RD;
                end
            end
            S_T0: state_next = S_T1;
            S_T1: state_next = S_T2;
            S_T2: state_next = S_T3;
            S_T3: state_next = S_T4;
            S_T4: state_next = S_D0;
            S_D0: state_next = S_D1;
            S_D1: state_next = S_D2;
            S_D2: state_next = S_D3;
            S_D3: state_next = S_D4;
            S_D4: state_next = S_GAIN;
            S_GAIN: begin
                if (stat.gain_pos) begin
                    again_next = 1'b1;
                    s_next     = CW'(1);
                    state_next = S_SW_RP;
                end else begin
                    state_next = S_KNEXT;
                end
            end
            S_SW_RP:  state_next = S_SW_RQ;
            S_SW_RQ:  state_next = S_SW_CAP;
            S_SW_CAP: state_next = S_SW_WP;
            S_SW_WP:  state_next = S_SW_WQ;
            S_SW_WQ: begin
                s_next = s_reg + 1'b1;
                if (((s_x + 1'b1) << 1) < r_x + XW'(2)) state_next = S_SW_RP;
                else                                   state_next = S_KNEXT;
            end
            S_KNEXT: begin
                if (k_x + 1'b1 < n_x) begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_T0;
                end else begin
                    r_next     = r_reg + 1'b1;
                    state_next = S_OPT_RCHK;
                end
            end
            S_EM_RD: state_next = S_EM_LD;
            S_EM_LD: state_next = S_EM_WAIT;
            S_EM_WAIT: begin
                if (m_ready) begin
                    if (XW'(i_reg) + 1'b1 == n_x) begin
                        cnt_next   = '0;
                        state_next = S_IDLE;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_EM_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        m_last  = 1'b0;
        ia      = i_reg[IW-1:0];
        ja      = j_reg[IW-1:0];
        ta      = i_reg[IW-1:0];
        case (state_reg)
            S_IDLE: begin
                s_ready    = 1'b1;
                ia         = cnt_reg[IW-1:0];
                cmd.xy_wr  = s_valid && room;
            end
            S_DIAG: begin
                cmd.dist_wr   = 1'b1;
                cmd.dist_zero = 1'b1;
                cmd.dsel      = DS_II;
            end
            S_XY_RD:   cmd.xy_rd = 1'b1;
            S_XY_WAIT: cmd.sq_load = 1'b1;
            S_SUM:     cmd.root_start = 1'b1;
            S_WR1: begin
                cmd.dist_wr = 1'b1;
                cmd.dsel    = DS_IJ;
            end
            S_WR2: begin
                cmd.dist_wr = 1'b1;
                cmd.dsel    = DS_JI;
            end
            S_NN_INIT: begin
                cmd.nn_init = 1'b1;
                cmd.tour_wr = 1'b1;
                cmd.twsel   = TW_ZERO;
                cmd.lop     = L_CLR;
                ta          = '0;
            end
            S_NN_POS: cmd.nn_pos = 1'b1;
            S_NN_RD: begin
                cmd.dist_rd = 1'b1;
                cmd.dsel    = DS_PJ;
            end
            S_NN_CMP: cmd.nn_cmp = 1'b1;
            S_NN_TAKE: begin
                cmd.nn_take = 1'b1;
                cmd.tour_wr = 1'b1;
                cmd.twsel   = TW_BEST;
                cmd.lop     = L_ADD_BEST;
            end
            S_NN_CLOSE: begin
                cmd.dist_rd = 1'b1;
                cmd.dsel    = DS_P0;
            end
            S_NN_CLOSE2: cmd.lop = L_ADD_RD;
            S_T0: begin
                cmd.tour_rd = 1'b1;
                ta          = k_reg[IW-1:0];
            end
            S_T1: begin
                cmd.cap     = CAP_A;
                cmd.tour_rd = 1'b1;
                ta          = pos_b[IW-1:0];
            end
            S_T2: begin
                cmd.cap     = CAP_B;
                cmd.tour_rd = 1'b1;
                ta          = pos_c[IW-1:0];
            end
            S_T3: begin
                cmd.cap     = CAP_C;
                cmd.tour_rd = 1'b1;
                ta          = pos_d[IW-1:0];
            end
            S_T4: cmd.cap = CAP_D;
            S_D0: begin
                cmd.dist_rd = 1'b1;
                cmd.dsel    = DS_AB;
            end
            S_D1: begin
                cmd.gop     = G_LOAD;
                cmd.dist_rd = 1'b1;
                cmd.dsel    = DS_CD;
            end
            S_D2: begin
                cmd.gop     = G_ADD;
                cmd.dist_rd = 1'b1;
                cmd.dsel    = DS_AC;
            end
            S_D3: begin
                cmd.gop     = G_SUB;
                cmd.dist_rd = 1'b1;
                cmd.dsel    = DS_BD;
            end
            S_D4: cmd.gop = G_SUB;
            S_GAIN: begin
                if (stat.gain_pos) cmd.lop = L_SUB_GAIN;
            end
            S_SW_RP: begin
                cmd.tour_rd = 1'b1;
                ta          = pos_p[IW-1:0];
            end
            S_SW_RQ: begin
                cmd.cap     = CAP_P;
                cmd.tour_rd = 1'b1;
                ta          = pos_q[IW-1:0];
            end
            S_SW_CAP: cmd.cap = CAP_Q;
            S_SW_WP: begin
                cmd.tour_wr = 1'b1;
                cmd.twsel   = TW_TQ;
                ta          = pos_p[IW-1:0];
            end
            S_SW_WQ: begin
                cmd.tour_wr = 1'b1;
                cmd.twsel   = TW_TP;
                ta          = pos_q[IW-1:0];
            end
            S_EM_RD: cmd.tour_rd = 1'b1;
            S_EM_LD: cmd.cap = CAP_OUT;
            S_EM_WAIT: begin
                m_valid = 1'b1;
                m_last  = (XW'(i_reg) + 1'b1 == n_x);
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            r_reg     <= '0;
            k_reg     <= '0;
            s_reg     <= '0;
            again_reg <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            r_reg     <= r_next;
            k_reg     <= k_next;
            s_reg     <= s_next;
            again_reg <= again_next;
            last_reg  <= last_next;
        end
    end

endmodule

/* rtl/nntsp_dp.sv */
// Datapath: point, distance and tour memories, root unit, gain and length math.
// Depends on nntsp_pkg and nntsp_root; commanded by nntsp_ctrl.
`timescale 1ns / 1ps

module nntsp_dp
    import nntsp_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dp_cmd_t                       cmd,
    output dp_stat_t                      stat,
    input  logic [$clog2(MAX_POINTS)-1:0] ia,
    input  logic [$clog2(MAX_POINTS)-1:0] ja,
    input  logic [$clog2(MAX_POINTS)-1:0] ta,
    input  logic [COORD_BITS-1:0]         x_in,
    input  logic [COORD_BITS-1:0]         y_in,
    output logic [CITY_W-1:0]             city_out,
    output logic [LEN_W-1:0]              len_out
);

    localparam int IW    = $clog2(MAX_POINTS);
    localparam int PD    = 1 << IW;
    localparam int DW    = COORD_BITS + 1;
    localparam int GW    = DW + 3;
    localparam int CB    = COORD_BITS;

    logic [CB-1:0]  x_mem [PD];
    logic [CB-1:0]  y_mem [PD];
    logic [DW-1:0]  d_mem [PD*PD];
    logic [IW-1:0]  t_mem [PD];

    logic [CB-1:0]   xn_reg, yn_reg, xr_reg, yr_reg;
    logic [2*CB-1:0] dx2_reg, dy2_reg;
    logic [CB-1:0]   dx, dy;
    logic [DW-1:0]   dd_reg;
    logic [IW-1:0]   trd_reg;
    logic [IW-1:0]   a_reg, b_reg, c_reg, d_reg, tp_reg, tq_reg, out_reg;
    logic [IW-1:0]   prev_reg, best_reg;
    logic [DW-1:0]   bestd_reg;
    logic            found_reg;
    logic [PD-1:0]   visited_reg;
    logic signed [GW-1:0] gain_reg, dd_s;
    logic [LEN_W-1:0] len_reg;

    logic [IW-1:0]   row, col;
    logic [IW-1:0]   twdata;
    logic [DW-1:0]   root_dist;
    logic            root_done;
    logic            better;

    nntsp_root #(.COORD_BITS(COORD_BITS)) u_root (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.root_start),
        .operand  ({1'b0, dx2_reg} + {1'b0, dy2_reg}),
        .done     (root_done),
        .root_out (root_dist)
    );

    assign dx = (xn_reg > xr_reg) ? xn_reg - xr_reg : xr_reg - xn_reg;
    assign dy = (yn_reg > yr_reg) ? yn_reg - yr_reg : yr_reg - yn_reg;

    // point stores and squared deltas
    always_ff @(posedge aclk) begin
        if (cmd.xy_wr) begin
            x_mem[ia] <= x_in;
            y_mem[ia] <= y_in;
            xn_reg    <= x_in;
            yn_reg    <= y_in;
        end
        if (cmd.xy_rd) begin
            xr_reg <= x_mem[ja];
            yr_reg <= y_mem[ja];
        end
        if (cmd.sq_load) begin
            dx2_reg <= dx * dx;
            dy2_reg <= dy * dy;
        end
    end

    always_comb begin
        case (cmd.dsel)
            DS_II:   begin row = ia;       col = ia;     end
            DS_IJ:   begin row = ia;       col = ja;     end
            DS_JI:   begin row = ja;       col = ia;     end
            DS_PJ:   begin row = prev_reg; col = ja;     end
            DS_P0:   begin row = prev_reg; col = '0;     end
            DS_AB:   begin row = a_reg;    col = b_reg;  end
            DS_CD:   begin row = c_reg;    col = d_reg;  end
            DS_AC:   begin row = a_reg;    col = c_reg;  end
            DS_BD:   begin row = b_reg;    col = d_reg;  end
            default: begin row = ia;       col = ja;     end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.dist_wr) d_mem[{row, col}] <= cmd.dist_zero ? '0 : root_dist;
        if (cmd.dist_rd) dd_reg <= d_mem[{row, col}];
    end

    always_comb begin
        case (cmd.twsel)
            TW_ZERO: twdata = '0;
            TW_BEST: twdata = best_reg;
            TW_TP:   twdata = tp_reg;
            TW_TQ:   twdata = tq_reg;
            default: twdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.tour_wr) t_mem[ta] <= twdata;
        if (cmd.tour_rd) trd_reg <= t_mem[ta];
        case (cmd.cap)
            CAP_A:   a_reg   <= trd_reg;
            CAP_B:   b_reg   <= trd_reg;
            CAP_C:   c_reg   <= trd_reg;
            CAP_D:   d_reg   <= trd_reg;
            CAP_P:   tp_reg  <= trd_reg;
            CAP_Q:   tq_reg  <= trd_reg;
            CAP_OUT: out_reg <= trd_reg;
            default: ;
        endcase
    end

    // nearest-neighbor selection: first strict minimum keeps the lowest index
    assign better = !visited_reg[ja] && (!found_reg || dd_reg < bestd_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            visited_reg <= '0;
            found_reg   <= 1'b0;
        end else if (cmd.nn_init) begin
            visited_reg <= PD'(1);
            found_reg   <= 1'b0;
        end else if (cmd.nn_pos) begin
            found_reg <= 1'b0;
        end else if (cmd.nn_cmp && better) begin
            found_reg <= 1'b1;
        end else if (cmd.nn_take) begin
            visited_reg[best_reg] <= 1'b1;
        end
        if (cmd.nn_init) prev_reg <= '0;
        else if (cmd.nn_take) prev_reg <= best_reg;
        if (cmd.nn_cmp && better) begin
            best_reg  <= ja;
            bestd_reg <= dd_reg;
        end
    end

    assign dd_s = signed'(GW'(dd_reg));

    always_ff @(posedge aclk) begin
        case (cmd.gop)
            G_LOAD:  gain_reg <= dd_s;
            G_ADD:   gain_reg <= gain_reg + dd_s;
            G_SUB:   gain_reg <= gain_reg - dd_s;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else begin
            case (cmd.lop)
                L_CLR:      len_reg <= '0;
                L_ADD_BEST: len_reg <= len_reg + LEN_W'(bestd_reg);
                L_ADD_RD:   len_reg <= len_reg + LEN_W'(dd_reg);
                L_SUB_GAIN: len_reg <= len_reg - LEN_W'(gain_reg);
                default:    ;
            endcase
        end
    end

    assign stat.root_done = root_done;
    assign stat.gain_pos  = gain_reg > 0;
    assign city_out       = CITY_W'(out_reg);
    assign len_out        = len_reg;

endmodule
